// ----- rtl/bmps_pkg.sv -----
// Shared types and field widths for the baker's map pixel scatter.
`timescale 1ns / 1ps
package bmps_pkg;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned STEP_W    = 8;
	localparam int unsigned COL_OUT_W = 9;
	localparam int unsigned ROW_OUT_W = 8;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} colour_t;

	typedef struct packed {
		logic adv;
		logic neg;
	} ctrl_t;

endpackage

// ----- rtl/bmps_ifs.sv -----
// Stream interfaces: source pixels, scattered pixels and the step count write.
`timescale 1ns / 1ps
interface bmps_pix_in_if;
	import bmps_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

interface bmps_pix_out_if;
	import bmps_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [COL_OUT_W-1:0] dest_col;
	logic [ROW_OUT_W-1:0] dest_row;
	logic [CH_W-1:0]      out_red;
	logic [CH_W-1:0]      out_green;
	logic [CH_W-1:0]      out_blue;
	logic                 frame_end;
	modport source (output valid, dest_col, dest_row, out_red, out_green, out_blue, frame_end,
		input ready);
	modport sink (input valid, dest_col, dest_row, out_red, out_green, out_blue, frame_end,
		output ready);
endinterface

interface bmps_cfg_if;
	import bmps_pkg::*;
	logic              valid;
	logic              ready;
	logic [STEP_W-1:0] step_count;
	modport source (output valid, step_count, input ready);
	modport sink (input valid, step_count, output ready);
endinterface

// ----- rtl/bmps_cell.sv -----
// Chain cell: forward/inverse map step if IDX < mag, else pass-through; registers the beat.
`timescale 1ns / 1ps
module bmps_cell #(
	parameter int unsigned FRAME_WIDTH  = 320,
	parameter int unsigned FRAME_HEIGHT = 240,
	parameter int unsigned CW           = 9,
	parameter int unsigned RW           = 8,
	parameter int unsigned MW           = 7,
	parameter int unsigned IDX          = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bmps_pkg::ctrl_t   ctrl,
	input  logic [MW-1:0]     mag,
	input  logic              v_in,
	input  logic [CW-1:0]     col_in,
	input  logic [RW-1:0]     row_in,
	input  bmps_pkg::colour_t colour_in,
	input  logic              last_in,
	output logic              v_s1,
	output logic [CW-1:0]     col_s1,
	output logic [RW-1:0]     row_s1,
	output bmps_pkg::colour_t colour_s1,
	output logic              last_s1
);
	import bmps_pkg::*;

	localparam logic [CW:0] FW_X  = (CW+1)'(FRAME_WIDTH);
	localparam logic [CW:0] FW2_X = (CW+1)'(2 * FRAME_WIDTH - 1);
	localparam logic [RW:0] FH_X  = (RW+1)'(FRAME_HEIGHT);
	localparam logic [RW:0] FH2_X = (RW+1)'(2 * FRAME_HEIGHT - 1);
	localparam logic [CW-1:0] FW1 = CW'(FRAME_WIDTH - 1);
	localparam logic [RW-1:0] FH1 = RW'(FRAME_HEIGHT - 1);
	localparam logic [MW-1:0] IDX_V = MW'(IDX);

	logic [CW:0]   fc_w;
	logic [RW:0]   ir_w;
	logic [CW-1:0] col_nx;
	logic [RW-1:0] row_nx;

	always_comb begin
		fc_w   = {col_in, row_in[0]};
		ir_w   = {row_in, col_in[0]};
		col_nx = col_in;
		row_nx = row_in;
		if (IDX_V < mag) begin
			if (ctrl.neg) begin
				if (ir_w >= FH_X) begin
					col_nx = FW1 - (col_in >> 1);
					row_nx = RW'(FH2_X - ir_w);
				end else begin
					col_nx = col_in >> 1;
					row_nx = RW'(ir_w);
				end
			end else begin
				if (fc_w >= FW_X) begin
					col_nx = CW'(FW2_X - fc_w);
					row_nx = FH1 - (row_in >> 1);
				end else begin
					col_nx = CW'(fc_w);
					row_nx = row_in >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ctrl.adv) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			col_s1    <= col_nx;
			row_s1    <= row_nx;
			colour_s1 <= colour_in;
			last_s1   <= last_in;
		end
	end

endmodule

// ----- rtl/bakers_map_pixel_scatter.sv -----
// Baker's map pixel scatter: raster counters feeding a chain of MAX_STEPS map cells.
// Throughput: one pixel per cycle while the output is not stalled; each cell
// below the step magnitude performs one map step per pixel; the others pass it on.
// A stall on the output holds the whole chain, and the input with it.
// Reset clears the raster counters, the step count and all valid flags.
`timescale 1ns / 1ps
module bakers_map_pixel_scatter #(
	parameter int unsigned FRAME_WIDTH  = 320,
	parameter int unsigned FRAME_HEIGHT = 240,
	parameter int unsigned MAX_STEPS    = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	bmps_pix_in_if.sink    pix_in,
	bmps_pix_out_if.source pix_out,
	bmps_cfg_if.sink       cfg
);
	import bmps_pkg::*;

	localparam int unsigned CW = $clog2(FRAME_WIDTH);
	localparam int unsigned RW = $clog2(FRAME_HEIGHT);
	localparam int unsigned MW = $clog2(MAX_STEPS + 1);
	localparam logic [CW-1:0] COL_LAST = CW'(FRAME_WIDTH - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(FRAME_HEIGHT - 1);

	logic [STEP_W-1:0] step_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [STEP_W-1:0] step_abs;
	logic [MW-1:0]     mag;
	ctrl_t             ctrl;
	logic              acc;
	logic              src_last;

	logic              v_c      [0:MAX_STEPS];
	logic [CW-1:0]     col_c    [0:MAX_STEPS];
	logic [RW-1:0]     row_c    [0:MAX_STEPS];
	colour_t           colour_c [0:MAX_STEPS];
	logic              last_c   [0:MAX_STEPS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cfg.valid) begin
			step_q <= cfg.step_count;
		end
	end

	assign ctrl.neg = step_q[STEP_W-1];

	always_comb begin
		step_abs = ctrl.neg ? (~step_q + STEP_W'(1)) : step_q;
		if (32'(step_abs) > 32'(MAX_STEPS)) begin
			mag = MW'(MAX_STEPS);
		end else begin
			mag = MW'(step_abs);
		end
	end

	assign ctrl.adv     = !v_c[MAX_STEPS] || pix_out.ready;
	assign pix_in.ready = ctrl.adv;
	assign acc          = pix_in.valid && ctrl.adv;
	assign src_last     = (col_q == COL_LAST) && (row_q == ROW_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_q == COL_LAST) begin
				col_q <= '0;
				row_q <= (row_q == ROW_LAST) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	assign v_c[0]            = pix_in.valid;
	assign col_c[0]          = col_q;
	assign row_c[0]          = row_q;
	assign colour_c[0].red   = pix_in.red;
	assign colour_c[0].green = pix_in.green;
	assign colour_c[0].blue  = pix_in.blue;
	assign last_c[0]         = src_last;

	for (genvar k = 0; k < MAX_STEPS; k++) begin : g_cell
		bmps_cell #(
			.FRAME_WIDTH  (FRAME_WIDTH),
			.FRAME_HEIGHT (FRAME_HEIGHT),
			.CW           (CW),
			.RW           (RW),
			.MW           (MW),
			.IDX          (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.mag       (mag),
			.v_in      (v_c[k]),
			.col_in    (col_c[k]),
			.row_in    (row_c[k]),
			.colour_in (colour_c[k]),
			.last_in   (last_c[k]),
			.v_s1      (v_c[k+1]),
			.col_s1    (col_c[k+1]),
			.row_s1    (row_c[k+1]),
			.colour_s1 (colour_c[k+1]),
			.last_s1   (last_c[k+1])
		);
	end

	assign pix_out.valid     = v_c[MAX_STEPS];
	assign pix_out.dest_col  = COL_OUT_W'(col_c[MAX_STEPS]);
	assign pix_out.dest_row  = ROW_OUT_W'(row_c[MAX_STEPS]);
	assign pix_out.out_red   = colour_c[MAX_STEPS].red;
	assign pix_out.out_green = colour_c[MAX_STEPS].green;
	assign pix_out.out_blue  = colour_c[MAX_STEPS].blue;
	assign pix_out.frame_end = last_c[MAX_STEPS];

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < 32'(FRAME_WIDTH)) && (32'(row_q) < 32'(FRAME_HEIGHT)))
		else $error("raster counter out of frame");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		acc && src_last |=> (col_q == '0) && (row_q == '0))
		else $error("counters did not wrap after last pixel");

	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(mag) <= 32'(MAX_STEPS))
		else $error("step magnitude above bound");

	a_dest_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_c[MAX_STEPS] |-> (32'(col_c[MAX_STEPS]) < 32'(FRAME_WIDTH)) &&
			(32'(row_c[MAX_STEPS]) < 32'(FRAME_HEIGHT)))
		else $error("destination outside frame");

endmodule
